// File: rtl/hti_pkg.sv
// Shared constants, types and address helper for the heightmap triangle interpolator.
package hti_pkg;

  localparam int GRID_SIZE  = 64;
  localparam int HEIGHT_W   = 16;
  localparam int POS_W      = 16;
  localparam int COORD_W    = 6;
  localparam int FRAC_W     = 8;
  localparam int WEIGHT_W   = FRAC_W + 1;
  localparam int WEIGHT_ONE = 1 << FRAC_W;
  localparam int OFFSET     = GRID_SIZE * (WEIGHT_ONE / 2);

  // Four banks split by column and row parity; each holds one corner of any cell.
  localparam int NUM_BANKS  = 4;
  localparam int BANK_SEL_W = 2;
  localparam int HALF       = (GRID_SIZE + 1) / 2;
  localparam int HALF_W     = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int BANK_DEPTH = HALF * HALF;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  localparam int RX_W       = POS_W + 2;
  localparam int CELL_W     = RX_W - 1 - FRAC_W;
  localparam int PROD_W     = HEIGHT_W + WEIGHT_W + 1;
  localparam int SUM_W      = PROD_W + 2;
  localparam int QUOT_W     = SUM_W - FRAC_W;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                       upper;
    logic [FRAC_W-1:0]          fx;
    logic [FRAC_W-1:0]          fz;
    logic signed [HEIGHT_W-1:0] h00;
    logic signed [HEIGHT_W-1:0] h10;
    logic signed [HEIGHT_W-1:0] h01;
    logic signed [HEIGHT_W-1:0] h11;
  } hti_corners_t;

  function automatic logic [BANK_AW-1:0] bank_addr(input logic [HALF_W-1:0] col_half,
                                                   input logic [HALF_W-1:0] row_half);
    return BANK_AW'(row_half) * BANK_AW'(HALF) + BANK_AW'(col_half);
  endfunction

endpackage

// File: rtl/hti_in_if.sv
// Input channel: write and query items with valid/ready handshake.
interface hti_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 operation;
  logic signed [hti_pkg::POS_W-1:0]     pos_x;
  logic signed [hti_pkg::POS_W-1:0]     pos_z;
  logic [hti_pkg::COORD_W-1:0]          grid_col;
  logic [hti_pkg::COORD_W-1:0]          grid_row;
  logic signed [hti_pkg::HEIGHT_W-1:0]  height_in;

  modport source (output valid, operation, pos_x, pos_z, grid_col, grid_row, height_in,
                  input ready);
  modport sink (input valid, operation, pos_x, pos_z, grid_col, grid_row, height_in,
                output ready);
endinterface

// File: rtl/hti_out_if.sv
// Output channel: interpolated height items with valid/ready handshake.
interface hti_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [hti_pkg::HEIGHT_W-1:0]  height_out;
  logic                                 in_range;

  modport source (output valid, height_out, in_range, input ready);
  modport sink (input valid, height_out, in_range, output ready);
endinterface

// File: rtl/hti_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hti_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/hti_blend.sv
// Triangle weights, registered corner products, floor shift and saturation.
module hti_blend (
  input  logic                                clk,
  input  logic                                en,
  input  hti_pkg::hti_corners_t               corners,
  output logic signed [hti_pkg::HEIGHT_W-1:0] result
);

  logic [hti_pkg::WEIGHT_W-1:0]       fsum;
  logic [hti_pkg::WEIGHT_W-1:0]       wa;
  logic [hti_pkg::WEIGHT_W-1:0]       wb;
  logic [hti_pkg::WEIGHT_W-1:0]       wc;
  logic signed [hti_pkg::HEIGHT_W-1:0] ha;
  logic signed [hti_pkg::PROD_W-1:0]  pa;
  logic signed [hti_pkg::PROD_W-1:0]  pb;
  logic signed [hti_pkg::PROD_W-1:0]  pc;
  logic signed [hti_pkg::SUM_W-1:0]   sum;
  logic signed [hti_pkg::QUOT_W-1:0]  quot;
  logic                               fits;

  always_comb begin
    fsum = {1'b0, corners.fx} + {1'b0, corners.fz};
    if (corners.upper) begin
      ha = corners.h11;
      wa = fsum - hti_pkg::WEIGHT_W'(hti_pkg::WEIGHT_ONE);
      wb = hti_pkg::WEIGHT_W'(hti_pkg::WEIGHT_ONE) - {1'b0, corners.fz};
      wc = hti_pkg::WEIGHT_W'(hti_pkg::WEIGHT_ONE) - {1'b0, corners.fx};
    end else begin
      ha = corners.h00;
      wa = hti_pkg::WEIGHT_W'(hti_pkg::WEIGHT_ONE) - fsum;
      wb = {1'b0, corners.fx};
      wc = {1'b0, corners.fz};
    end
  end

  // Hold products while the output is stalled.
  always_ff @(posedge clk) begin
    if (en) begin
      pa <= ha * $signed({1'b0, wa});
      pb <= corners.h10 * $signed({1'b0, wb});
      pc <= corners.h01 * $signed({1'b0, wc});
    end
  end

  always_comb begin
    sum  = hti_pkg::SUM_W'(pa) + hti_pkg::SUM_W'(pb) + hti_pkg::SUM_W'(pc);
    quot = sum[hti_pkg::SUM_W-1:hti_pkg::FRAC_W];
    fits = (quot[hti_pkg::QUOT_W-1:hti_pkg::HEIGHT_W-1] == '0) ||
           (quot[hti_pkg::QUOT_W-1:hti_pkg::HEIGHT_W-1] == '1);
    if (fits) begin
      result = quot[hti_pkg::HEIGHT_W-1:0];
    end else if (quot[hti_pkg::QUOT_W-1]) begin
      result = {1'b1, {(hti_pkg::HEIGHT_W-1){1'b0}}};
    end else begin
      result = {1'b0, {(hti_pkg::HEIGHT_W-1){1'b1}}};
    end
  end

endmodule

// File: rtl/heightmap_triangle_interpolator_core.sv
// Top level of the heightmap triangle interpolator: banked height store and query pipeline.
//
// Usage:
//   in_ch carries one item per handshake. operation selects a write (store height_in
//   at grid_col/grid_row) or a query (interpolate at world pos_x/pos_z, Q8.8).
//   out_ch returns exactly one item per input item, in order: height_out and in_range.
//   Writes and out-of-area queries return zero with in_range low.
// Timing:
//   One item per cycle sustained while out_ch takes results. A result passes through the
//   RAM read register, which loads at the accepting edge, then the corner products,
//   then the output reg.
//   The four cell corners come from four parity-split RAM banks in the same cycle,
//   so no item waits for another; a write is in the store before any later query reads.
// Reset:
//   rst clears the pipeline and starts a clearing pass that zeroes all four banks in
//   parallel, one address per cycle over BANK_DEPTH (1024) addresses, in_ch.ready low.
// Backpressure:
//   When out_ch stalls, the whole pipeline holds and in_ch.ready drops in the same
//   cycle; no item is lost or repeated.
module heightmap_triangle_interpolator_core (
  input  logic      clk,
  input  logic      rst,
  hti_in_if.sink    in_ch,
  hti_out_if.source out_ch
);

  logic                                  clearing;
  logic [hti_pkg::BANK_AW-1:0]           clear_cnt;
  logic                                  advance;
  logic                                  accept;

  logic signed [hti_pkg::RX_W-1:0]       rx;
  logic signed [hti_pkg::RX_W-1:0]       rz;
  logic [hti_pkg::CELL_W-1:0]            cx;
  logic [hti_pkg::CELL_W-1:0]            cz;
  logic                                  query_ok;
  logic                                  write_ok;
  logic [hti_pkg::WEIGHT_W-1:0]          fsum;

  logic                                  bank_we    [hti_pkg::NUM_BANKS];
  logic [hti_pkg::BANK_AW-1:0]           bank_waddr [hti_pkg::NUM_BANKS];
  logic [hti_pkg::HEIGHT_W-1:0]          bank_wdata [hti_pkg::NUM_BANKS];
  logic [hti_pkg::BANK_AW-1:0]           bank_raddr [hti_pkg::NUM_BANKS];
  logic [hti_pkg::HEIGHT_W-1:0]          bank_rdata [hti_pkg::NUM_BANKS];

  logic                                  s1_valid;
  logic                                  s1_ok;
  logic                                  s1_upper;
  logic [hti_pkg::FRAC_W-1:0]            s1_fx;
  logic [hti_pkg::FRAC_W-1:0]            s1_fz;
  logic                                  s1_cx0;
  logic                                  s1_cz0;
  logic                                  s2_valid;
  logic                                  s2_ok;
  logic                                  out_valid;
  logic signed [hti_pkg::HEIGHT_W-1:0]   height_out;
  logic                                  in_range;

  hti_pkg::hti_corners_t                 corners;
  logic signed [hti_pkg::HEIGHT_W-1:0]   blend_result;

  // Advance every stage together whenever the output register is free or drains.
  assign advance     = !out_valid || out_ch.ready;
  assign in_ch.ready = advance && !clearing;
  assign accept      = in_ch.valid && in_ch.ready;

  // Shift the query so the grid centers on the origin, then split cell and fraction.
  always_comb begin
    rx       = hti_pkg::RX_W'(in_ch.pos_x) + hti_pkg::RX_W'(hti_pkg::OFFSET);
    rz       = hti_pkg::RX_W'(in_ch.pos_z) + hti_pkg::RX_W'(hti_pkg::OFFSET);
    cx       = rx[hti_pkg::RX_W-2:hti_pkg::FRAC_W];
    cz       = rz[hti_pkg::RX_W-2:hti_pkg::FRAC_W];
    query_ok = (in_ch.operation == hti_pkg::OP_QUERY) &&
               !rx[hti_pkg::RX_W-1] && !rz[hti_pkg::RX_W-1] &&
               (cx <= hti_pkg::CELL_W'(hti_pkg::GRID_SIZE - 2)) &&
               (cz <= hti_pkg::CELL_W'(hti_pkg::GRID_SIZE - 2));
    write_ok = (in_ch.operation == hti_pkg::OP_WRITE) &&
               ({3'b000, in_ch.grid_col} < 9'(hti_pkg::GRID_SIZE)) &&
               ({3'b000, in_ch.grid_row} < 9'(hti_pkg::GRID_SIZE));
    fsum     = {1'b0, rx[hti_pkg::FRAC_W-1:0]} + {1'b0, rz[hti_pkg::FRAC_W-1:0]};
  end

  // Bank b holds points with column parity b[0] and row parity b[1].
  always_comb begin
    logic [hti_pkg::CELL_W-1:0]    colc;
    logic [hti_pkg::CELL_W-1:0]    rowc;
    logic [hti_pkg::BANK_SEL_W-1:0] sel;
    for (int b = 0; b < hti_pkg::NUM_BANKS; b++) begin
      sel  = hti_pkg::BANK_SEL_W'(b);
      colc = cx + hti_pkg::CELL_W'(cx[0] ^ sel[0]);
      rowc = cz + hti_pkg::CELL_W'(cz[0] ^ sel[1]);
      bank_raddr[b] = hti_pkg::bank_addr(hti_pkg::HALF_W'(colc >> 1),
                                         hti_pkg::HALF_W'(rowc >> 1));
      if (clearing) begin
        bank_we[b]    = 1'b1;
        bank_waddr[b] = clear_cnt;
        bank_wdata[b] = '0;
      end else begin
        bank_we[b]    = accept && write_ok &&
                        (sel == {in_ch.grid_row[0], in_ch.grid_col[0]});
        bank_waddr[b] = hti_pkg::bank_addr(hti_pkg::HALF_W'(in_ch.grid_col >> 1),
                                           hti_pkg::HALF_W'(in_ch.grid_row >> 1));
        bank_wdata[b] = in_ch.height_in;
      end
    end
  end

  for (genvar g = 0; g < hti_pkg::NUM_BANKS; g++) begin : g_bank
    hti_ram #(
      .WIDTH (hti_pkg::HEIGHT_W),
      .DEPTH (hti_pkg::BANK_DEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (bank_we[g]),
      .waddr (bank_waddr[g]),
      .wdata (bank_wdata[g]),
      .re    (accept),
      .raddr (bank_raddr[g]),
      .rdata (bank_rdata[g])
    );
  end

  // Control state: clearing pass and stage valids.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clear_cnt <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clear_cnt <= clear_cnt + 1'b1;
        if (clear_cnt == hti_pkg::BANK_AW'(hti_pkg::BANK_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (advance) begin
        s1_valid  <= accept;
        s2_valid  <= s1_valid;
        out_valid <= s2_valid;
      end
    end
  end

  // Stage payloads; RAM read data stays put while nothing is accepted.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ok    <= query_ok;
      s1_upper <= fsum > hti_pkg::WEIGHT_W'(hti_pkg::WEIGHT_ONE);
      s1_fx    <= rx[hti_pkg::FRAC_W-1:0];
      s1_fz    <= rz[hti_pkg::FRAC_W-1:0];
      s1_cx0   <= cx[0];
      s1_cz0   <= cz[0];
    end
    if (advance) begin
      s2_ok      <= s1_ok;
      height_out <= s2_ok ? blend_result : '0;
      in_range   <= s2_ok;
    end
  end

  // Map banks back to cell corners using the cell's parity.
  always_comb begin
    corners.upper = s1_upper;
    corners.fx    = s1_fx;
    corners.fz    = s1_fz;
    corners.h00   = bank_rdata[{s1_cz0, s1_cx0}];
    corners.h10   = bank_rdata[{s1_cz0, ~s1_cx0}];
    corners.h01   = bank_rdata[{~s1_cz0, s1_cx0}];
    corners.h11   = bank_rdata[{~s1_cz0, ~s1_cx0}];
  end

  hti_blend u_blend (
    .clk     (clk),
    .en      (advance),
    .corners (corners),
    .result  (blend_result)
  );

  assign out_ch.valid      = out_valid;
  assign out_ch.height_out = height_out;
  assign out_ch.in_range   = in_range;

endmodule

// File: verif/heightmap_triangle_interpolator_core_tb.sv
// Self-checking testbench for the heightmap triangle interpolator core.
`timescale 1ns / 1ps

module heightmap_triangle_interpolator_core_tb;
  import hti_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_ITEMS   = 550;

  typedef struct {
    logic                       operation;
    logic signed [POS_W-1:0]    pos_x;
    logic signed [POS_W-1:0]    pos_z;
    logic [COORD_W-1:0]         grid_col;
    logic [COORD_W-1:0]         grid_row;
    logic signed [HEIGHT_W-1:0] height_in;
  } terrain_item_t;

  typedef struct {
    logic signed [HEIGHT_W-1:0] height_out;
    logic                       in_range;
  } height_sample_t;

  logic clk = 1'b0;
  logic rst;

  hti_in_if  in_ch ();
  hti_out_if out_ch ();

  heightmap_triangle_interpolator_core DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Shadow copy of the height grid, indexed row * GRID_SIZE + col.
  logic signed [HEIGHT_W-1:0] terrain_heights [GRID_SIZE*GRID_SIZE];

  terrain_item_t  item_backlog [$];
  height_sample_t expected_heights [$];

  logic in_taken;
  logic out_taken;
  logic in_calm;
  logic out_calm;
  int   in_gap_left;
  int   out_stall_left;
  int   idle_cycles;
  int   error_count;

  // Pick an idle length: mostly short, a few long, none in a calm stretch.
  function automatic int gap_length(input logic calm);
    int p;
    p = $urandom_range(0, 99);
    if (calm) return 0;
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Compute the height on the selected triangle of the cell under (px, pz).
  function automatic height_sample_t interpolate_height(input logic signed [POS_W-1:0] px,
                                                        input logic signed [POS_W-1:0] pz);
    height_sample_t r;
    int rx, rz, cx, cz, fx, fz;
    int h00, h10, h01, h11;
    int acc, q;
    r.height_out = '0;
    r.in_range   = 1'b0;
    rx = int'(px) + OFFSET;
    rz = int'(pz) + OFFSET;
    if (rx >= 0 && rz >= 0) begin
      cx = rx >> FRAC_W;
      cz = rz >> FRAC_W;
      fx = rx & (WEIGHT_ONE - 1);
      fz = rz & (WEIGHT_ONE - 1);
      // The last row and column have no cell of their own.
      if (cx <= GRID_SIZE - 2 && cz <= GRID_SIZE - 2) begin
        h00 = terrain_heights[cz * GRID_SIZE + cx];
        h10 = terrain_heights[cz * GRID_SIZE + cx + 1];
        h01 = terrain_heights[(cz + 1) * GRID_SIZE + cx];
        h11 = terrain_heights[(cz + 1) * GRID_SIZE + cx + 1];
        // fx + fz exactly one still counts as the lower triangle.
        if (fx + fz <= WEIGHT_ONE)
          acc = h00 * (WEIGHT_ONE - fx - fz) + h10 * fx + h01 * fz;
        else
          acc = h10 * (WEIGHT_ONE - fz) + h11 * (fx + fz - WEIGHT_ONE)
              + h01 * (WEIGHT_ONE - fx);
        q = acc >>> FRAC_W;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        r.height_out = q[HEIGHT_W-1:0];
        r.in_range   = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic queue_write(input int col, input int row, input int h);
    terrain_item_t it;
    it.operation = OP_WRITE;
    it.pos_x     = $urandom();
    it.pos_z     = $urandom();
    it.grid_col  = col[COORD_W-1:0];
    it.grid_row  = row[COORD_W-1:0];
    it.height_in = h[HEIGHT_W-1:0];
    item_backlog.push_back(it);
  endtask

  task automatic queue_query(input int x, input int z);
    terrain_item_t it;
    it.operation = OP_QUERY;
    it.pos_x     = x[POS_W-1:0];
    it.pos_z     = z[POS_W-1:0];
    it.grid_col  = $urandom();
    it.grid_row  = $urandom();
    it.height_in = $urandom();
    item_backlog.push_back(it);
  endtask

  function automatic int random_height();
    int p;
    p = $urandom_range(0, 99);
    if (p < 10) return 32767;
    if (p < 20) return -32768;
    if (p < 50) return $urandom_range(0, 2047) - 1024;
    return int'($signed(16'($urandom())));
  endfunction

  task automatic build_stimulus();
    int base_x, base_z, p, col, row, fx, fz;
    // Directed: extreme heights on the first cell, then probe its triangles.
    queue_write(0, 0, 32767);
    queue_write(1, 0, -32768);
    queue_write(0, 1, 32767);
    queue_write(1, 1, -32768);
    queue_query(-OFFSET, -OFFSET);
    queue_query(-OFFSET + 128, -OFFSET + 128);
    queue_query(-OFFSET + 255, -OFFSET + 255);
    queue_query(-OFFSET + 255, -OFFSET);
    queue_query(-OFFSET, -OFFSET + 255);
    queue_query(-OFFSET + 1, -OFFSET + 255);
    // Far corner: last valid cell, then the excluded last row and column.
    queue_write(63, 63, 16'h1234);
    queue_write(62, 62, -1);
    queue_write(63, 62, -32768);
    queue_write(62, 63, 32767);
    queue_query(62 * 256 - OFFSET + 200, 62 * 256 - OFFSET + 40);
    queue_query(63 * 256 - OFFSET, 0);
    queue_query(0, 63 * 256 - OFFSET);
    queue_query(-OFFSET - 1, 0);
    queue_query(0, -OFFSET - 1);
    queue_query(-32768, -32768);
    queue_query(32767, 32767);
    queue_query(-1, 0);

    // Random: mostly writes and queries clustered on a moving window of cells.
    base_x = $urandom_range(0, 61);
    base_z = $urandom_range(0, 61);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 39) == 0) begin
        base_x = $urandom_range(0, 61);
        base_z = $urandom_range(0, 61);
      end
      p = $urandom_range(0, 99);
      if (p < 40) begin
        col = base_x + $urandom_range(0, 2);
        row = base_z + $urandom_range(0, 2);
        queue_write(col, row, random_height());
      end else if (p < 85) begin
        case ($urandom_range(0, 4))
          0:       begin fx = 0;   fz = $urandom_range(0, 255); end
          1:       begin fx = 255; fz = $urandom_range(0, 255); end
          2:       begin fx = $urandom_range(0, 255); fz = 256 - fx; end
          default: begin fx = $urandom_range(0, 255); fz = $urandom_range(0, 255); end
        endcase
        if (fz > 255) fz = 255;
        queue_query((base_x + $urandom_range(0, 1)) * 256 + fx - OFFSET,
                    (base_z + $urandom_range(0, 1)) * 256 + fz - OFFSET);
      end else if (p < 92) begin
        queue_write($urandom_range(0, 63), $urandom_range(0, 63), random_height());
      end else begin
        queue_query(int'($signed(16'($urandom()))), int'($signed(16'($urandom()))));
      end
    end
  endtask

  // Drive the input channel at the falling edge; hold an item until it is taken.
  always @(negedge clk) begin
    terrain_item_t it;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
      // hold the current item
    end else if (in_gap_left > 0) begin
      in_ch.valid <= 1'b0;
      in_gap_left <= in_gap_left - 1;
    end else if (item_backlog.size() > 0) begin
      it = item_backlog.pop_front();
      in_ch.operation <= it.operation;
      in_ch.pos_x     <= it.pos_x;
      in_ch.pos_z     <= it.pos_z;
      in_ch.grid_col  <= it.grid_col;
      in_ch.grid_row  <= it.grid_row;
      in_ch.height_in <= it.height_in;
      in_ch.valid     <= 1'b1;
      if ($urandom_range(0, 63) == 0) in_calm <= ~in_calm;
      in_gap_left <= gap_length(in_calm);
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Drive ready at the falling edge: stall after some results and now and then at random.
  always @(negedge clk) begin
    int n;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (out_stall_left > 0) begin
      out_ch.ready   <= 1'b0;
      out_stall_left <= out_stall_left - 1;
    end else if (out_taken) begin
      if ($urandom_range(0, 63) == 0) out_calm <= ~out_calm;
      n = gap_length(out_calm);
      if (n > 0) begin
        out_ch.ready   <= 1'b0;
        out_stall_left <= n - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end else if (!out_calm && $urandom_range(0, 15) == 0) begin
      out_ch.ready   <= 1'b0;
      out_stall_left <= $urandom_range(0, 3);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Sample both channels at the rising edge: predict on input, check on output.
  always @(posedge clk) begin
    height_sample_t want;
    logic in_fire, out_fire;
    in_fire  = !rst && in_ch.valid && in_ch.ready;
    out_fire = !rst && out_ch.valid && out_ch.ready;
    in_taken  <= in_fire;
    out_taken <= out_fire;

    if (in_fire) begin
      if (in_ch.operation == OP_WRITE) begin
        // Every 6-bit coordinate lies inside the 64-point grid.
        terrain_heights[int'(in_ch.grid_row) * GRID_SIZE + int'(in_ch.grid_col)] =
          in_ch.height_in;
        want.height_out = '0;
        want.in_range   = 1'b0;
      end else begin
        want = interpolate_height(in_ch.pos_x, in_ch.pos_z);
      end
      expected_heights.push_back(want);
    end

    if (out_fire) begin
      if (expected_heights.size() == 0) begin
        $display("%0t: unexpected result height_out=%0d in_range=%0b",
                 $time, out_ch.height_out, out_ch.in_range);
        error_count++;
      end else begin
        want = expected_heights.pop_front();
        if (out_ch.height_out !== want.height_out) begin
          $display("%0t: height_out expected %0d actual %0d",
                   $time, want.height_out, out_ch.height_out);
          error_count++;
        end
        if (out_ch.in_range !== want.in_range) begin
          $display("%0t: in_range expected %0b actual %0b",
                   $time, want.in_range, out_ch.in_range);
          error_count++;
        end
      end
    end

    // Count cycles with no item moving on either side; the clearing pass is included.
    if (in_fire || out_fire) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding",
               $time, expected_heights.size());
      $display("heightmap_triangle_interpolator_core test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst             = 1'b1;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_WRITE;
    in_ch.pos_x     = '0;
    in_ch.pos_z     = '0;
    in_ch.grid_col  = '0;
    in_ch.grid_row  = '0;
    in_ch.height_in = '0;
    out_ch.ready    = 1'b0;
    in_taken        = 1'b0;
    out_taken       = 1'b0;
    in_calm         = 1'b0;
    out_calm        = 1'b0;
    in_gap_left     = 0;
    out_stall_left  = 0;
    idle_cycles     = 0;
    error_count     = 0;
    foreach (terrain_heights[i]) terrain_heights[i] = '0;
    build_stimulus();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Drain: all items sent, all results back, then a quiet spell.
    @(posedge clk);
    while (item_backlog.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_heights.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("heightmap_triangle_interpolator_core test passed");
    end else begin
      $display("heightmap_triangle_interpolator_core test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/hti_pkg.sv
rtl/hti_in_if.sv
rtl/hti_out_if.sv
rtl/hti_ram.sv
rtl/hti_blend.sv
rtl/heightmap_triangle_interpolator_core.sv
verif/heightmap_triangle_interpolator_core_tb.sv
